FILE: rtl/lrucache_pkg.sv
`default_nettype none

package lrucache_pkg;

  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    OP_FETCH  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STORE  = 2'd2,
    OP_MODIFY = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_e;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [1:0]         b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {{(TOTAL_W-1){1'b0}}, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lru_set_assoc_cache_model_top.sv
// Set-associative cache model with least-recently-used replacement.
// Request channel: in_valid_i / in_stall_o with operation_i and address_i.
// Result channel: out_valid_o / out_stall_i with this request's hit count,
// miss and eviction flags and the saturating running totals.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects set_bits (0),
// block_bits (1) or ways_in_use (2); writes are always taken.
// Each set is one row of a synchronous memory holding every way's valid bit,
// tag and stamp. A request is accepted while idle (its row is read into a
// register); the next cycle compares tags, writes the row back (a fetch writes
// nothing) and loads the result register, waiting while that register is full.
// An eviction with more than one way in use walks the stamps one way per
// cycle to find the oldest. One request is in flight at a time.
// After reset all 2**MAX_SET_BITS rows (256 by default) are cleared one row per
// cycle, with in_stall_o high. The result sits in an output register: a new
// request is taken while it waits, and the block holds its next result (no write
// back, no stamp advance) until the register is free.
`default_nettype none

module lru_set_assoc_cache_model_top #(
  parameter int unsigned MAX_SET_BITS = 8,
  parameter int unsigned WAYS         = 8,
  parameter int unsigned ADDR_BITS    = 48
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          operation_i,
  input  wire logic [ADDR_BITS-1:0]                address_i,

  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               hit_count_o,
  output logic                                     was_miss_o,
  output logic                                     was_eviction_o,
  output logic [lrucache_pkg::TOTAL_W-1:0]         total_hits_o,
  output logic [lrucache_pkg::TOTAL_W-1:0]         total_misses_o,
  output logic [lrucache_pkg::TOTAL_W-1:0]         total_evictions_o,

  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [lrucache_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lrucache_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WC_W     = $clog2(WAYS + 1);
  localparam int unsigned SB_W     = $clog2(MAX_SET_BITS + 1);
  localparam int unsigned SH_W     = $clog2(MAX_SET_BITS + 32);
  localparam int unsigned STAMP_W  = lrucache_pkg::STAMP_W;
  localparam int unsigned TOTAL_W  = lrucache_pkg::TOTAL_W;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] tag;
    logic [STAMP_W-1:0]   stamp;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  // configuration
  logic [3:0] set_bits_q;
  logic [4:0] block_bits_q;
  logic [3:0] ways_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 4'd4;
      block_bits_q <= 5'd4;
      ways_q       <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lrucache_pkg::cfg_idx_e'(cfg_index_i))
        lrucache_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_data_i[3:0];
        lrucache_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        lrucache_pkg::CFG_WAYS:       ways_q       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [SB_W-1:0] set_eff;
  logic [WC_W-1:0] ways_eff;
  logic [4:0]      ways_tmp;

  always_comb begin
    if (5'(set_bits_q) > 5'(MAX_SET_BITS)) begin
      set_eff = SB_W'(MAX_SET_BITS);
    end else begin
      set_eff = SB_W'(set_bits_q);
    end
    if (ways_q == 4'd0) begin
      ways_tmp = 5'd1;
    end else if (5'(ways_q) > 5'(WAYS)) begin
      ways_tmp = 5'(WAYS);
    end else begin
      ways_tmp = 5'(ways_q);
    end
    ways_eff = WC_W'(ways_tmp);
  end

  // address split
  logic [ADDR_BITS-1:0]    addr_shift;
  logic [SH_W-1:0]         tag_shamt;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] set_idx;
  logic [ADDR_BITS-1:0]    tag_in;

  always_comb begin
    addr_shift = address_i >> block_bits_q;
    set_mask   = ~({MAX_SET_BITS{1'b1}} << set_eff);
    set_idx    = addr_shift[MAX_SET_BITS-1:0] & set_mask;
    tag_shamt  = SH_W'(set_eff) + SH_W'(block_bits_q);
    tag_in     = address_i >> tag_shamt;
  end

  // control and request registers
  lrucache_pkg::state_e    state_q, state_d;
  lrucache_pkg::op_e       op_q;
  logic [MAX_SET_BITS-1:0] set_q;
  logic [ADDR_BITS-1:0]    tag_q;
  logic [MAX_SET_BITS-1:0] clr_q, clr_d;
  logic [WAY_W-1:0]        scan_q, scan_d;
  logic [WAY_W-1:0]        oldest_q, oldest_d;
  logic [STAMP_W-1:0]      stamp_q;
  logic [TOTAL_W-1:0]      hit_total_q, miss_total_q, evict_total_q;

  logic in_acc;
  assign in_stall_o = (state_q != lrucache_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // set memory
  row_t                    line_mem [NUM_SETS];
  row_t                    row_q;
  row_t                    mem_wdata;
  logic                    mem_we;
  logic                    mem_re;
  logic [MAX_SET_BITS-1:0] mem_waddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      row_q <= line_mem[set_idx];
    end
  end

  // lookup on the registered row
  logic [WAYS-1:0]  hit_vec, inv_vec;
  logic [WAY_W-1:0] hit_way, inv_way;
  logic             any_hit, any_inv;

  always_comb begin
    for (int unsigned w = 0; w < WAYS; w++) begin
      hit_vec[w] = (WC_W'(w) < ways_eff) && row_q[w].valid && (row_q[w].tag == tag_q);
      inv_vec[w] = (WC_W'(w) < ways_eff) && !row_q[w].valid;
    end
    any_hit = |hit_vec;
    any_inv = |inv_vec;
    hit_way = '0;
    inv_way = '0;
    // lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (inv_vec[w]) begin
        inv_way = WAY_W'(w);
      end
    end
  end

  // finish of one request
  logic             fin, fin_write, fin_miss, fin_evict, fin_hit;
  logic [WAY_W-1:0] fin_way;
  logic [WAY_W-1:0] cand;
  logic             scan_last;
  logic             out_ready, out_load;
  logic [1:0]       fin_hits;

  assign out_ready = !out_valid_o || !out_stall_i;
  assign scan_last = (WC_W'(scan_q) == ways_eff - WC_W'(1));
  assign cand      = (row_q[scan_q].stamp < row_q[oldest_q].stamp) ? scan_q : oldest_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    scan_d    = scan_q;
    oldest_d  = oldest_q;
    fin       = 1'b0;
    fin_write = 1'b0;
    fin_hit   = 1'b0;
    fin_miss  = 1'b0;
    fin_evict = 1'b0;
    fin_way   = '0;
    mem_re    = 1'b0;
    unique case (state_q)
      lrucache_pkg::S_CLEAR: begin
        clr_d = clr_q + MAX_SET_BITS'(1);
        if (clr_q == {MAX_SET_BITS{1'b1}}) begin
          state_d = lrucache_pkg::S_IDLE;
        end
      end
      lrucache_pkg::S_IDLE: begin
        if (in_acc) begin
          mem_re  = 1'b1;
          state_d = lrucache_pkg::S_LOOK;
        end
      end
      lrucache_pkg::S_LOOK: begin
        priority if (op_q == lrucache_pkg::OP_FETCH) begin
          fin = 1'b1;
        end else if (any_hit) begin
          fin       = 1'b1;
          fin_write = 1'b1;
          fin_hit   = 1'b1;
          fin_way   = hit_way;
        end else if (any_inv) begin
          fin       = 1'b1;
          fin_write = 1'b1;
          fin_miss  = 1'b1;
          fin_way   = inv_way;
        end else if (ways_eff == WC_W'(1)) begin
          fin       = 1'b1;
          fin_write = 1'b1;
          fin_miss  = 1'b1;
          fin_evict = 1'b1;
        end else begin
          // all ways valid: walk the stamps for the oldest
          state_d  = lrucache_pkg::S_SCAN;
          oldest_d = '0;
          scan_d   = WAY_W'(1);
        end
        if (fin && out_ready) begin
          state_d = lrucache_pkg::S_IDLE;
        end
      end
      lrucache_pkg::S_SCAN: begin
        if (scan_last) begin
          fin       = 1'b1;
          fin_write = 1'b1;
          fin_miss  = 1'b1;
          fin_evict = 1'b1;
          fin_way   = cand;
          if (out_ready) begin
            state_d = lrucache_pkg::S_IDLE;
          end
        end else begin
          oldest_d = cand;
          scan_d   = scan_q + WAY_W'(1);
        end
      end
      default: begin
        state_d = lrucache_pkg::S_IDLE;
      end
    endcase
  end

  assign out_load = fin && out_ready;

  always_comb begin
    if (state_q == lrucache_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = out_load && fin_write;
      mem_waddr = set_q;
      mem_wdata = row_q;
      mem_wdata[fin_way].valid = 1'b1;
      mem_wdata[fin_way].tag   = tag_q;
      mem_wdata[fin_way].stamp = stamp_q;
    end
  end

  always_comb begin
    if (op_q == lrucache_pkg::OP_MODIFY) begin
      fin_hits = fin_hit ? 2'd2 : 2'd1;
    end else begin
      fin_hits = fin_hit ? 2'd1 : 2'd0;
    end
    if (op_q == lrucache_pkg::OP_FETCH) begin
      fin_hits = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= lrucache_pkg::S_CLEAR;
      clr_q         <= '0;
      scan_q        <= '0;
      oldest_q      <= '0;
      stamp_q       <= STAMP_W'(1);
      hit_total_q   <= '0;
      miss_total_q  <= '0;
      evict_total_q <= '0;
      out_valid_o   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      scan_q   <= scan_d;
      oldest_q <= oldest_d;
      if (out_load) begin
        stamp_q       <= stamp_q + STAMP_W'(1);
        hit_total_q   <= lrucache_pkg::sat_add(hit_total_q, fin_hits);
        miss_total_q  <= lrucache_pkg::sat_add(miss_total_q, {1'b0, fin_miss});
        evict_total_q <= lrucache_pkg::sat_add(evict_total_q, {1'b0, fin_evict});
        out_valid_o   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= lrucache_pkg::op_e'(operation_i);
      set_q <= set_idx;
      tag_q <= tag_in;
    end
    if (out_load) begin
      hit_count_o    <= fin_hits;
      was_miss_o     <= fin_miss;
      was_eviction_o <= fin_evict;
    end
  end

  assign total_hits_o      = hit_total_q;
  assign total_misses_o    = miss_total_q;
  assign total_evictions_o = evict_total_q;

  // checks
  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == lrucache_pkg::S_LOOK))
    else $error("accepted request did not move to lookup");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrucache_pkg::S_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_stamp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (stamp_q == $past(stamp_q) + STAMP_W'(1)))
    else $error("access stamp did not advance with the result");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrucache_pkg::S_SCAN) |-> (WC_W'(scan_q) < ways_eff))
    else $error("stamp walk beyond the ways in use");

  a_hits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (hit_total_q >= $past(hit_total_q)))
    else $error("hit total decreased");

endmodule

`default_nettype wire

FILE: test/lru_cache_checker.sv
`default_nettype none

module lru_cache_checker #(
  parameter int unsigned MAX_SET_BITS = 8,
  parameter int unsigned WAYS         = 8,
  parameter int unsigned ADDR_BITS    = 48
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                in_valid_i,
  input  wire logic                                in_stall_i,
  input  wire logic [1:0]                          operation_i,
  input  wire logic [ADDR_BITS-1:0]                address_i,

  input  wire logic                                out_valid_i,
  input  wire logic                                out_stall_i,
  input  wire logic [1:0]                          hit_count_i,
  input  wire logic                                was_miss_i,
  input  wire logic                                was_eviction_i,
  input  wire logic [lrucache_pkg::TOTAL_W-1:0]    total_hits_i,
  input  wire logic [lrucache_pkg::TOTAL_W-1:0]    total_misses_i,
  input  wire logic [lrucache_pkg::TOTAL_W-1:0]    total_evictions_i,

  input  wire logic                                cfg_valid_i,
  input  wire logic                                cfg_ready_i,
  input  wire logic [lrucache_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lrucache_pkg::CFG_DATA_W-1:0] cfg_data_i,

  output int                                       err_count_o,
  output int                                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES = (2 ** MAX_SET_BITS) * WAYS;
  localparam int unsigned TOTAL_W = lrucache_pkg::TOTAL_W;

  typedef struct packed {
    logic [1:0]         hits;
    logic               miss;
    logic               evict;
    logic [TOTAL_W-1:0] total_hits;
    logic [TOTAL_W-1:0] total_misses;
    logic [TOTAL_W-1:0] total_evictions;
  } access_outcome_t;

  logic               line_valid [LINES];
  logic [63:0]        line_tag   [LINES];
  logic [63:0]        line_stamp [LINES];
  logic [63:0]        access_stamp;
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;
  logic [TOTAL_W-1:0] evict_total;

  logic [3:0]         set_bits_q;
  logic [4:0]         block_bits_q;
  logic [3:0]         ways_q;

  access_outcome_t    outcome_q [$];

  function automatic logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] t, int unsigned n);
    return (t > {TOTAL_W{1'b1}} - n) ? {TOTAL_W{1'b1}} : t + n;
  endfunction

  // one access against the shadow cache; updates the lines, stamp and totals (a fetch only the stamp)
  function automatic access_outcome_t access_cache(logic [1:0] op,
                                                   logic [ADDR_BITS-1:0] addr);
    access_outcome_t r;
    int              s;
    int              b;
    int              nways;
    int              base;
    int              found;
    int              empty;
    int              oldest;
    logic [63:0]     a64;
    logic [63:0]     tag;
    r      = '0;
    s      = (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_q;
    b      = block_bits_q;
    nways  = (ways_q == 0) ? 1 : ((ways_q > WAYS) ? WAYS : ways_q);
    a64    = 64'(addr);
    if (op != lrucache_pkg::OP_FETCH) begin
      base   = int'((a64 >> b) & ((64'd1 << s) - 64'd1)) * WAYS;
      tag    = a64 >> (s + b);
      found  = -1;
      empty  = -1;
      oldest = 0;
      for (int w = 0; w < nways; w++) begin
        if (found < 0 && line_valid[base+w] && line_tag[base+w] == tag) found = w;
      end
      if (found >= 0) begin
        line_stamp[base+found] = access_stamp;
        r.hits = (op == lrucache_pkg::OP_MODIFY) ? 2'd2 : 2'd1;
      end else begin
        r.miss = 1'b1;
        for (int w = 0; w < nways; w++) begin
          if (empty < 0 && !line_valid[base+w]) empty = w;
        end
        if (empty >= 0) begin
          line_valid[base+empty] = 1'b1;
          line_tag[base+empty]   = tag;
          line_stamp[base+empty] = access_stamp;
        end else begin
          // strict compare keeps the lowest way on a stamp tie
          for (int w = 1; w < nways; w++) begin
            if (line_stamp[base+w] < line_stamp[base+oldest]) oldest = w;
          end
          line_tag[base+oldest]   = tag;
          line_stamp[base+oldest] = access_stamp;
          r.evict = 1'b1;
        end
        if (op == lrucache_pkg::OP_MODIFY) r.hits = 2'd1;
      end
      hit_total   = bump(hit_total, r.hits);
      miss_total  = bump(miss_total, r.miss);
      evict_total = bump(evict_total, r.evict);
    end
    access_stamp      = access_stamp + 64'd1;
    r.total_hits      = hit_total;
    r.total_misses    = miss_total;
    r.total_evictions = evict_total;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    err_count_o++;
  endtask

  task automatic check_field(string name, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_stamp[i] = '0;
      end
      access_stamp = 64'd1;
      hit_total    = '0;
      miss_total   = '0;
      evict_total  = '0;
      set_bits_q   = 4'd4;
      block_bits_q = 5'd4;
      ways_q       = 4'd1;
      outcome_q.delete();
      err_count_o  = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no outstanding request");
        end else begin
          want = outcome_q.pop_front();
          check_field("hit_count", 32'(hit_count_i), 32'(want.hits));
          check_field("was_miss", 32'(was_miss_i), 32'(want.miss));
          check_field("was_eviction", 32'(was_eviction_i), 32'(want.evict));
          check_field("total_hits", total_hits_i, want.total_hits);
          check_field("total_misses", total_misses_i, want.total_misses);
          check_field("total_evictions", total_evictions_i, want.total_evictions);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          lrucache_pkg::CFG_SET_BITS:   set_bits_q   = cfg_data_i[3:0];
          lrucache_pkg::CFG_BLOCK_BITS: block_bits_q = cfg_data_i;
          lrucache_pkg::CFG_WAYS:       ways_q       = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) outcome_q.push_back(access_cache(operation_i, address_i));
      pending_o = outcome_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_lru_set_assoc_cache_model_top.sv
`default_nettype none

module tb_lru_set_assoc_cache_model_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SET_BITS = 8;
  localparam int unsigned WAYS         = 8;
  localparam int unsigned ADDR_BITS    = 48;
  localparam int unsigned TOTAL_W      = lrucache_pkg::TOTAL_W;
  localparam int unsigned CFG_IDX_W    = lrucache_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W   = lrucache_pkg::CFG_DATA_W;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int STALL_HOLD      = 300;
  localparam int HOLD_AT         = 700;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 157;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;

  logic                  in_valid  = 1'b0;
  logic [1:0]            operation = lrucache_pkg::OP_FETCH;
  logic [ADDR_BITS-1:0]  address   = '0;
  logic                  in_stall;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            hit_count;
  logic                  was_miss;
  logic                  was_eviction;
  logic [TOTAL_W-1:0]    total_hits;
  logic [TOTAL_W-1:0]    total_misses;
  logic [TOTAL_W-1:0]    total_evictions;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = lrucache_pkg::CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int err_count;
  int pending;
  int sent_count  = 0;
  int cycle_count = 0;
  int hold_left   = 0;
  bit hold_used   = 1'b0;
  bit calm        = 1'b0;

  int cur_set_bits   = 4;
  int cur_block_bits = 4;
  int cur_ways       = 1;

  lru_set_assoc_cache_model_top #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .WAYS        (WAYS),
    .ADDR_BITS   (ADDR_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (operation),
    .address_i        (address),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .hit_count_o      (hit_count),
    .was_miss_o       (was_miss),
    .was_eviction_o   (was_eviction),
    .total_hits_o     (total_hits),
    .total_misses_o   (total_misses),
    .total_evictions_o(total_evictions),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  lru_cache_checker #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .WAYS        (WAYS),
    .ADDR_BITS   (ADDR_BITS)
  ) chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .operation_i      (operation),
    .address_i        (address),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .hit_count_i      (hit_count),
    .was_miss_i       (was_miss),
    .was_eviction_i   (was_eviction),
    .total_hits_i     (total_hits),
    .total_misses_i   (total_misses),
    .total_evictions_i(total_evictions),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lru_set_assoc_cache_model_top: done, errors");
      $finish;
    end
  end

  // result side: random stall, plus one long hold once enough requests went in
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_used && sent_count >= HOLD_AT) begin
      hold_used = 1'b1;
      hold_left = STALL_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 22);
    end
  end

  task automatic put_req(lrucache_pkg::op_e op, logic [ADDR_BITS-1:0] a);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 22) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    address   <= a;
    do @(posedge clk_i); while (in_stall);
    sent_count++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      lrucache_pkg::CFG_SET_BITS:   cur_set_bits   = val & 15;
      lrucache_pkg::CFG_BLOCK_BITS: cur_block_bits = val & 31;
      lrucache_pkg::CFG_WAYS:       cur_ways       = val & 15;
      default: ;
    endcase
  endtask

  function automatic int eff_set_bits();
    return (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cur_set_bits;
  endfunction

  function automatic logic [ADDR_BITS-1:0] build_addr(logic [63:0] tag, int set_idx,
                                                      logic [63:0] off);
    logic [63:0] a;
    int          s;
    int          b;
    s = eff_set_bits();
    b = cur_block_bits;
    a = (tag << (s + b)) | (64'(set_idx) << b) | (off & ((64'd1 << b) - 64'd1));
    return a[ADDR_BITS-1:0];
  endfunction

  // requests mostly reuse a few sets and as many tags as ways or up to three more,
  // so hits, fills and evictions all come up
  task automatic run_phase(int n_items);
    logic [63:0]          tags [16];
    int                   sets [4];
    int                   nsets;
    int                   ntags;
    int                   ways_eff;
    logic [ADDR_BITS-1:0] a;
    lrucache_pkg::op_e    op;
    ways_eff = (cur_ways == 0) ? 1 : ((cur_ways > WAYS) ? WAYS : cur_ways);
    nsets    = $urandom_range(1, 3);
    ntags    = ways_eff + $urandom_range(0, 3);
    for (int i = 0; i < nsets; i++) sets[i] = $urandom_range(0, (1 << eff_set_bits()) - 1);
    for (int i = 0; i < ntags; i++) tags[i] = {$urandom, $urandom};
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < 85)
        a = build_addr(tags[$urandom_range(0, ntags - 1)], sets[$urandom_range(0, nsets - 1)],
                       {$urandom, $urandom});
      else
        a = ADDR_BITS'({$urandom, $urandom});
      if ($urandom_range(99) < 10) op = lrucache_pkg::OP_FETCH;
      else op = lrucache_pkg::op_e'($urandom_range(1, 3));
      put_req(op, a);
    end
  endtask

  initial begin
    int sb;
    int bb;
    int wb;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: 16 sets, 16-byte blocks, direct mapped
    put_req(lrucache_pkg::OP_FETCH,  48'h0);
    put_req(lrucache_pkg::OP_LOAD,   48'h0);
    put_req(lrucache_pkg::OP_LOAD,   48'h8);
    put_req(lrucache_pkg::OP_STORE,  48'hF);
    put_req(lrucache_pkg::OP_MODIFY, 48'h0);
    put_req(lrucache_pkg::OP_MODIFY, 48'h100);
    put_req(lrucache_pkg::OP_STORE,  48'h100);
    put_req(lrucache_pkg::OP_LOAD,   48'hFFFF_FFFF_FFFF);
    put_req(lrucache_pkg::OP_FETCH,  48'hFFFF_FFFF_FFFF);
    put_req(lrucache_pkg::OP_MODIFY, 48'hFFFF_FFFF_FFFF);
    put_req(lrucache_pkg::OP_STORE,  48'h0);
    drain_results();

    // widen to all ways with lines present, fill set 0, then evict by age
    write_reg(lrucache_pkg::CFG_WAYS, WAYS);
    for (int t = 1; t < 8; t++) put_req(lrucache_pkg::OP_LOAD, ADDR_BITS'(t << 8));
    put_req(lrucache_pkg::OP_LOAD,   48'h100);
    put_req(lrucache_pkg::OP_STORE,  48'h800);
    put_req(lrucache_pkg::OP_MODIFY, 48'h900);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin sb = 1;  bb = 1;  wb = 1;  end
        1:       begin sb = 8;  bb = 16; wb = 8;  end
        2:       begin sb = 4;  bb = 4;  wb = 8;  end
        3:       begin sb = 0;  bb = 0;  wb = 0;  end
        4:       begin sb = 15; bb = 31; wb = 15; end
        5:       begin sb = 2;  bb = 5;  wb = 4;  end
        6:       begin sb = 8;  bb = 1;  wb = 2;  end
        7:       begin sb = 3;  bb = 12; wb = 8;  end
        default: begin
          sb = $urandom_range(0, 15);
          bb = $urandom_range(0, 31);
          wb = $urandom_range(0, 15);
        end
      endcase
      write_reg(lrucache_pkg::CFG_SET_BITS, sb);
      write_reg(lrucache_pkg::CFG_BLOCK_BITS, bb);
      write_reg(lrucache_pkg::CFG_WAYS, wb);
      if (p == 5) write_reg(CFG_UNUSED, $urandom_range(0, 31));
      calm = (p == 2);
      run_phase(ITEMS_PER_PHASE);
      drain_results();
    end
    calm = 1'b0;

    repeat (20) @(negedge clk_i);
    if (err_count == 0)
      $display("tb_lru_set_assoc_cache_model_top: done, clean");
    else
      $display("tb_lru_set_assoc_cache_model_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/lrucache_pkg.sv
rtl/lru_set_assoc_cache_model_top.sv
test/lru_cache_checker.sv
test/tb_lru_set_assoc_cache_model_top.sv
